### rtl/led_pkg.sv
// shared types and constants for the line editing core
// no dependencies; used by line_editing_discipline_core
`default_nettype none

package led_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LIM_W  = 7;

  localparam logic [LIM_W-1:0] LIM_RESET = 7'd40;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_EOT   = 8'h04;  // ctrl-d
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_ETB   = 8'h17;  // ctrl-w
  localparam logic [CHAR_W-1:0] CH_NAK   = 8'h15;  // ctrl-u
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [ACT_W-1:0] {
    ACT_ECHO       = 3'd0,
    ACT_NEWLINE    = 3'd1,
    ACT_ERASE      = 3'd2,
    ACT_ERASE_LINE = 3'd3,
    ACT_BELL       = 3'd4,
    ACT_END        = 3'd5
  } action_e;

  typedef struct packed {
    action_e            act;
    logic [CHAR_W-1:0]  ch;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

### rtl/led_line_ram.sv
// line character store: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module led_line_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/line_editing_discipline_core.sv
// top level of the line editing core: control sequencer and result register
// depends on led_pkg and led_line_ram
`default_nettype none

// Takes one keyboard byte per transfer and gives display actions, one per
// output transfer, with tlast on the final action of each byte. A printable
// byte that wraps the line gives a newline, then the echo. Ctrl-w takes the
// byte, fetches the last character from the line memory, then gives one
// erase per erased character as the memory is read from the end of the
// line backwards. A full action register holds off the next byte until the
// sink takes the action, and it also holds off each erase of a ctrl-w.
// The line limit may only be written while no byte is in progress; 0 acts
// as 1 and values above MAX_LINE act as MAX_LINE. After ctrl-d on an empty
// line every byte is taken and dropped until reset.
module line_editing_discipline_core #(
  parameter int unsigned MAX_LINE = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // action stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [2:0] action, [10:3] out_char, rest zero
  output logic             m_axis_tlast,   // last
  // line limit register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i      // line_limit
);

  localparam int unsigned LEN_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam logic [led_pkg::LIM_W-1:0] MAX_LIM = led_pkg::LIM_W'(MAX_LINE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ECHO = 2'd1;
  localparam logic [1:0] ST_WORD = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [LEN_W-1:0]             len_q, len_d;
  logic                         ended_q, ended_d;
  logic                         word_q, word_d;   // past trailing spaces
  logic                         pend_q, pend_d;   // erase owed, last flag not known yet
  logic [7:0]                   hold_q, hold_d;
  logic [led_pkg::LIM_W-1:0]    lim_q;
  logic                         out_valid_q;
  led_pkg::res_t                out_q, res_d;
  logic                         out_load;

  logic                         slot_free, accept, printable, cont;
  logic [led_pkg::LIM_W-1:0]    eff_lim, len_ext;
  logic                         we;
  logic [ADDR_W-1:0]            waddr, raddr;
  logic [7:0]                   wdata, rdata;
  logic [LEN_W-1:0]             len_m1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= led_pkg::LIM_RESET;
    end else if (cfg_valid_i) begin
      lim_q <= cfg_data_i;
    end
  end

  always_comb begin
    eff_lim = lim_q;
    if (lim_q == '0) begin
      eff_lim = led_pkg::LIM_W'(1);
    end else if (lim_q > MAX_LIM) begin
      eff_lim = MAX_LIM;
    end
  end

  assign len_ext   = led_pkg::LIM_W'(len_q);
  assign slot_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign printable = (s_axis_tdata >= led_pkg::CH_SPACE) && (s_axis_tdata <= led_pkg::CH_TILDE);
  // word erase keeps going unless the line is empty or a space ends the word
  assign cont      = (len_q != '0) && !(word_q && (rdata == led_pkg::CH_SPACE));

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    ended_d  = ended_q;
    word_d   = word_q;
    pend_d   = pend_q;
    hold_d   = hold_q;
    out_load = 1'b0;
    res_d    = '{act: led_pkg::ACT_BELL, ch: '0, last: 1'b1};
    we       = 1'b0;
    waddr    = len_q[ADDR_W-1:0];
    wdata    = s_axis_tdata;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && !ended_q) begin
          if (printable) begin
            we = 1'b1;
            if (len_ext >= eff_lim) begin
              // wrap: newline first, echo goes out next
              waddr    = '0;
              len_d    = LEN_W'(1);
              hold_d   = s_axis_tdata;
              out_load = 1'b1;
              res_d    = '{act: led_pkg::ACT_NEWLINE, ch: '0, last: 1'b0};
              state_d  = ST_ECHO;
            end else begin
              len_d    = len_q + LEN_W'(1);
              out_load = 1'b1;
              res_d    = '{act: led_pkg::ACT_ECHO, ch: s_axis_tdata, last: 1'b1};
            end
          end else begin
            unique case (s_axis_tdata)
              led_pkg::CH_EOT: begin
                if (len_q == '0) begin
                  ended_d  = 1'b1;
                  out_load = 1'b1;
                  res_d    = '{act: led_pkg::ACT_END, ch: '0, last: 1'b1};
                end
              end
              led_pkg::CH_BS, led_pkg::CH_DEL: begin
                if (len_q != '0) begin
                  len_d    = len_q - LEN_W'(1);
                  out_load = 1'b1;
                  res_d    = '{act: led_pkg::ACT_ERASE, ch: '0, last: 1'b1};
                end
              end
              led_pkg::CH_ETB: begin
                word_d  = 1'b0;
                pend_d  = 1'b0;
                state_d = ST_WORD;
              end
              led_pkg::CH_NAK: begin
                len_d    = '0;
                out_load = 1'b1;
                res_d    = '{act: led_pkg::ACT_ERASE_LINE, ch: '0, last: 1'b1};
              end
              default: begin
                out_load = 1'b1;
                res_d    = '{act: led_pkg::ACT_BELL, ch: '0, last: 1'b1};
              end
            endcase
          end
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          out_load = 1'b1;
          res_d    = '{act: led_pkg::ACT_ECHO, ch: hold_q, last: 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_WORD: begin
        // rdata holds the character at len_q - 1
        if (!pend_q || slot_free) begin
          if (pend_q) begin
            out_load = 1'b1;
            res_d    = '{act: led_pkg::ACT_ERASE, ch: '0, last: !cont};
          end
          if (cont) begin
            len_d  = len_q - LEN_W'(1);
            pend_d = 1'b1;
            word_d = word_q || (rdata != led_pkg::CH_SPACE);
          end else begin
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // read follows the next line end (len_d - 1), so the registered read data is the character at len_q - 1
  assign len_m1 = len_d - LEN_W'(1);
  assign raddr  = len_m1[ADDR_W-1:0];

  led_line_ram #(
    .DEPTH  (MAX_LINE),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      ended_q     <= 1'b0;
      word_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ended_q <= ended_d;
      word_q  <= word_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.ch, out_q.act};
  assign m_axis_tlast  = out_q.last;

  // line never grows past the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LINE))
    else $error("line length beyond store depth");

  // a result is only loaded into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result register overwritten");

  // once the session has ended nothing more is produced
  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !out_load)
    else $error("result after end of session");

  // echoed characters are always printable
  a_echo_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_d.act == led_pkg::ACT_ECHO)) |->
      ((res_d.ch >= led_pkg::CH_SPACE) && (res_d.ch <= led_pkg::CH_TILDE)))
    else $error("non-printable echo");

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking bench for line_editing_discipline_core: keystroke driver, action sink
// and an in-bench line editor that predicts every display action; needs led_pkg
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LINE_MAX    = 64;
  localparam int unsigned SETTLE_CYC  = 80;    // longest word erase plus margin
  localparam int unsigned STALL_LIMIT = 4000;

  // holds the editor state and the queue of display actions still owed
  class edit_action_board;
    logic [7:0]    line_chars [LINE_MAX];
    int unsigned   held_count;
    bit            session_over;
    logic [6:0]    wrap_limit;
    led_pkg::res_t owed_actions [$];
    int unsigned   errors;

    function new();
      held_count   = 0;
      session_over = 1'b0;
      wrap_limit   = led_pkg::LIM_RESET;
      errors       = 0;
    endfunction

    function void owe(led_pkg::action_e a, logic [7:0] c);
      led_pkg::res_t r;
      r.act  = a;
      r.ch   = c;
      r.last = 1'b0;
      owed_actions.push_back(r);
    endfunction

    // note an accepted keystroke and queue the actions it must cause
    function void take_key(logic [7:0] key);
      int unsigned   lim;
      int unsigned   first;
      led_pkg::res_t tail;
      if (session_over) return;
      first = owed_actions.size();
      lim = (wrap_limit == 0) ? 1 : ((wrap_limit > LINE_MAX) ? LINE_MAX : wrap_limit);
      if (key >= led_pkg::CH_SPACE && key <= led_pkg::CH_TILDE) begin
        if (held_count >= lim) begin
          owe(led_pkg::ACT_NEWLINE, 8'h00);
          held_count = 0;
        end
        line_chars[held_count] = key;
        held_count++;
        owe(led_pkg::ACT_ECHO, key);
      end else begin
        case (key)
          led_pkg::CH_EOT: begin
            if (held_count == 0) begin
              session_over = 1'b1;
              owe(led_pkg::ACT_END, 8'h00);
            end
          end
          led_pkg::CH_BS, led_pkg::CH_DEL: begin
            if (held_count > 0) begin
              held_count--;
              owe(led_pkg::ACT_ERASE, 8'h00);
            end
          end
          led_pkg::CH_ETB: begin
            // trailing spaces go first, then the word before them
            while (held_count > 0 && line_chars[held_count-1] == led_pkg::CH_SPACE) begin
              held_count--;
              owe(led_pkg::ACT_ERASE, 8'h00);
            end
            while (held_count > 0 && line_chars[held_count-1] != led_pkg::CH_SPACE) begin
              held_count--;
              owe(led_pkg::ACT_ERASE, 8'h00);
            end
          end
          led_pkg::CH_NAK: begin
            held_count = 0;
            owe(led_pkg::ACT_ERASE_LINE, 8'h00);
          end
          default: owe(led_pkg::ACT_BELL, 8'h00);
        endcase
      end
      if (owed_actions.size() > first) begin
        tail = owed_actions.pop_back();
        tail.last = 1'b1;
        owed_actions.push_back(tail);
      end
    endfunction

    function void match_action(logic [15:0] data, logic is_last);
      led_pkg::res_t want;
      if (owed_actions.size() == 0) begin
        $display("%0t: unexpected action, expected none, got act %0d char %h last %b",
                 $time, data[2:0], data[10:3], is_last);
        errors++;
        return;
      end
      want = owed_actions.pop_front();
      if (data[2:0] !== want.act) begin
        $display("%0t: action mismatch, expected %0d, got %0d", $time, want.act, data[2:0]);
        errors++;
      end
      if (data[10:3] !== want.ch) begin
        $display("%0t: char mismatch, expected %h, got %h", $time, want.ch, data[10:3]);
        errors++;
      end
      if (is_last !== want.last) begin
        $display("%0t: tlast mismatch, expected %b, got %b", $time, want.last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;

  edit_action_board sb;
  bit               rush_tx;
  bit               rush_rx;
  int unsigned      quiet_cycles;
  logic [7:0]       opening [$];

  line_editing_discipline_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_key(input logic [7:0] key);
    int unsigned gap;
    if ($urandom_range(0, 14) == 0) rush_tx = !rush_tx;
    gap = rush_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_key(key);
  endtask

  // stop sending, let every owed action drain, then let the core go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [6:0] lim);
    cfg_data_i  <= lim;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.wrap_limit = lim;
  endtask

  // mostly words and spaces with edits mixed in, plus some raw noise
  function automatic logic [7:0] pick_key();
    int unsigned roll;
    logic [7:0]  k;
    roll = $urandom_range(0, 99);
    if (roll < 50)      k = 8'($urandom_range(8'h21, 8'h7E));
    else if (roll < 65) k = led_pkg::CH_SPACE;
    else if (roll < 73) k = roll[0] ? led_pkg::CH_BS : led_pkg::CH_DEL;
    else if (roll < 80) k = led_pkg::CH_ETB;
    else if (roll < 83) k = led_pkg::CH_NAK;
    else if (roll < 86) k = led_pkg::CH_EOT;
    else                k = 8'($urandom_range(0, 255));
    // ending the session here would silence the rest of the run
    if (k == led_pkg::CH_EOT && sb.held_count == 0) k = led_pkg::CH_NAK;
    return k;
  endfunction

  task automatic random_keys(input int unsigned count);
    repeat (count) send_key(pick_key());
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    rush_tx = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word erase over spaces and words, edits on an empty line, bells
    opening = '{8'h41, led_pkg::CH_SPACE, led_pkg::CH_SPACE, 8'h62, led_pkg::CH_TILDE,
                led_pkg::CH_SPACE, led_pkg::CH_SPACE, led_pkg::CH_ETB, led_pkg::CH_ETB,
                led_pkg::CH_ETB, led_pkg::CH_BS, led_pkg::CH_DEL, led_pkg::CH_NAK, 8'h78,
                led_pkg::CH_EOT, led_pkg::CH_DEL, 8'h7A, led_pkg::CH_NAK, 8'h00, 8'hFF,
                8'h80, 8'h1F, 8'h09, 8'h0A};
    foreach (opening[i]) send_key(opening[i]);
    settle();

    write_limit(7'd0);
    random_keys(6);
    settle();

    // one full-length word, erased in one go, then a full line again
    write_limit(7'd64);
    send_key(led_pkg::CH_NAK);
    repeat (LINE_MAX) send_key(8'($urandom_range(8'h21, 8'h7E)));
    send_key(led_pkg::CH_ETB);
    repeat (LINE_MAX) send_key(8'($urandom_range(8'h20, 8'h7E)));
    settle();

    // over-range limit acts as the maximum, so the full line wraps at once
    write_limit(7'd127);
    send_key(8'h51);
    random_keys(6);
    settle();

    write_limit(7'd1);
    random_keys(6);
    settle();

    write_limit(7'd64);
    repeat (20) send_key(8'($urandom_range(8'h21, 8'h7E)));
    settle();

    // limit dropped below the current length
    write_limit(7'd3);
    random_keys(6);
    settle();

    write_limit(7'($urandom_range(2, 63)));
    random_keys(6);
    settle();

    write_limit(led_pkg::LIM_RESET);
    random_keys(6);
    settle();

    // end of session, then bytes that must be swallowed
    send_key(led_pkg::CH_NAK);
    send_key(led_pkg::CH_EOT);
    send_key(led_pkg::CH_EOT);
    repeat (6) send_key(8'($urandom_range(0, 255)));
    settle();

    if (sb.errors == 0 && sb.owed_actions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // action sink with random back-pressure
  initial begin
    int unsigned gap;
    rush_rx = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 14) == 0) rush_rx = !rush_rx;
      gap = rush_rx ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.match_action(m_axis_tdata, m_axis_tlast);
    end
  end

  // counts cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/led_pkg.sv
rtl/led_line_ram.sv
rtl/line_editing_discipline_core.sv
tb/tb.sv
